/* rtl/lfpwm_pkg.sv */
// lfpwm_pkg: shared types, constants and control-word layout for the line-follow PID
// wheel mixer. No dependencies; imported by every module in rtl/.
`timescale 1ns / 1ps

package lfpwm_pkg;

	// integral width (range 16..32)
	localparam int SUM_WIDTH = 24;

	localparam int SENSOR_W = 8;
	localparam int SPEED_W  = 8;
	localparam int GAIN_W   = 16;
	localparam int ERR_W    = 9;
	localparam int DERIV_W  = ERR_W + 1;
	localparam int PID_W    = 16;
	localparam int CFG_W    = 16;
	localparam int CFG_IDX_W = 3;

	// shared multiplier: A carries error/derivative/integral/reciprocal, B gains/magnitudes
	localparam int RECIP_W  = 23;
	localparam int MA_W     = (SUM_WIDTH > RECIP_W) ? SUM_WIDTH : RECIP_W;
	localparam int MB_W     = 18;
	localparam int PROD_W   = MA_W + MB_W;
	localparam int ACC_W    = PROD_W + 2;

	// n/5 == (n * RECIP) >> RECIP_SHIFT, exact for n < 2^17
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_VAL   = 3355444;
	localparam int MAG_W       = 17;
	localparam int QUO_W       = 15;

	localparam logic [ERR_W-1:0] SENSOR_CENTER = ERR_W'(127);

	localparam logic [1:0] MODE_STRAIGHT = 2'd0;
	localparam logic [1:0] MODE_RIGHT    = 2'd1;
	localparam logic [1:0] MODE_LEFT     = 2'd2;
	localparam logic [1:0] MODE_HOLD     = 2'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GAIN_P     = 3'd0,
		CFG_GAIN_I     = 3'd1,
		CFG_GAIN_D     = 3'd2,
		CFG_BASE_LEFT  = 3'd3,
		CFG_BASE_RIGHT = 3'd4,
		CFG_TURN_MODE  = 3'd5,
		CFG_REVERSE    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [SPEED_W-1:0]       base_left;
		logic [SPEED_W-1:0]       base_right;
		logic [1:0]               turn_mode;
		logic                     reverse;
	} cfg_t;

	// microcode
	localparam int STEP_W = 4;

	typedef enum logic [1:0] {A_ERR, A_DERIV, A_SUM, A_RECIP} a_sel_t;
	typedef enum logic [2:0] {B_GP, B_GI, B_GD, B_NL, B_NR} b_sel_t;
	typedef enum logic [1:0] {ACC_KEEP, ACC_LOAD, ACC_ADD} acc_op_t;
	typedef enum logic {JC_NONE, JC_HOLD} jcond_t;

	typedef struct packed {
		a_sel_t             a_sel;
		b_sel_t             b_sel;
		acc_op_t            acc_op;
		logic               sum_wr;
		logic               pid_wr;
		logic               left_wr;
		logic               right_wr;
		logic               emit;
		jcond_t             jcond;
		logic [STEP_W-1:0]  jtgt;
	} ctrl_t;

	localparam logic [STEP_W-1:0] STEP_EMIT = STEP_W'(8);

	localparam ctrl_t CTRL_NOP = '{a_sel: A_ERR, b_sel: B_GP, acc_op: ACC_KEEP,
		sum_wr: 1'b0, pid_wr: 1'b0, left_wr: 1'b0, right_wr: 1'b0, emit: 1'b0,
		jcond: JC_NONE, jtgt: '0};

endpackage

/* rtl/lfpwm_seq.sv */
// lfpwm_seq: step counter and microcode store for the PID/mixer program.
// Depends on lfpwm_pkg (ctrl_t, step constants).
`timescale 1ns / 1ps

module lfpwm_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              hold,
	input  logic              stall,
	output logic              busy,
	output lfpwm_pkg::ctrl_t  ctrl
);
	import lfpwm_pkg::*;

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	ctrl_t             rom_word;

	// program: products feed the accumulator one step behind the multiply
	always_comb begin
		rom_word = CTRL_NOP;
		unique case (step_q)
			STEP_W'(0): begin
				rom_word.a_sel = A_ERR;
				rom_word.b_sel = B_GP;
				rom_word.jcond = JC_HOLD;
				rom_word.jtgt  = STEP_EMIT;
			end
			STEP_W'(1): begin
				rom_word.sum_wr = 1'b1;
				rom_word.a_sel  = A_DERIV;
				rom_word.b_sel  = B_GD;
				rom_word.acc_op = ACC_LOAD;
			end
			STEP_W'(2): begin
				rom_word.a_sel  = A_SUM;
				rom_word.b_sel  = B_GI;
				rom_word.acc_op = ACC_ADD;
			end
			STEP_W'(3): rom_word.acc_op = ACC_ADD;
			STEP_W'(4): rom_word.pid_wr = 1'b1;
			STEP_W'(5): begin
				rom_word.a_sel = A_RECIP;
				rom_word.b_sel = B_NL;
			end
			STEP_W'(6): begin
				rom_word.a_sel   = A_RECIP;
				rom_word.b_sel   = B_NR;
				rom_word.left_wr = 1'b1;
			end
			STEP_W'(7): rom_word.right_wr = 1'b1;
			STEP_EMIT:  rom_word.emit = 1'b1;
			default:    rom_word = CTRL_NOP;
		endcase
	end

	assign ctrl = busy_q ? rom_word : CTRL_NOP;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q) begin
			if (rom_word.emit) begin
				if (!stall) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end
			end else if (rom_word.jcond == JC_HOLD && hold) begin
				step_q <= rom_word.jtgt;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

endmodule

/* rtl/lfpwm_dp.sv */
// lfpwm_dp: datapath for the PID/mixer: error and integral registers, shared multiplier,
// accumulator, PID saturation and wheel mixing. Depends on lfpwm_pkg.
`timescale 1ns / 1ps

module lfpwm_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             load,
	input  logic [lfpwm_pkg::SENSOR_W-1:0]   sensor_value,
	input  lfpwm_pkg::cfg_t                  cfg,
	input  lfpwm_pkg::ctrl_t                 ctrl,
	output logic [lfpwm_pkg::SPEED_W-1:0]    left_speed,
	output logic [lfpwm_pkg::SPEED_W-1:0]    right_speed
);
	import lfpwm_pkg::*;

	logic signed [ERR_W-1:0]     err_q, prior_q, err_raw, err_new;
	logic signed [DERIV_W-1:0]   deriv_q;
	logic signed [SUM_WIDTH-1:0] sum_q;
	logic signed [SUM_WIDTH:0]   sum_ext;
	logic signed [MA_W-1:0]      mul_a;
	logic signed [MB_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [ACC_W-1:0]     acc_q, acc_adj, acc_sh;
	logic signed [PID_W-1:0]     pid_q, pid_sat;
	logic signed [MB_W-1:0]      pid3, xl3, xr3;
	logic [MAG_W-1:0]            nl, nr;
	logic [QUO_W-1:0]            quo;
	logic [SPEED_W-1:0]          left_q, right_q, left_nxt, right_nxt;

	function automatic logic [MAG_W-1:0] mag_for_div5(input logic signed [MB_W-1:0] x);
		logic [MB_W-1:0] neg_x;
		neg_x = MB_W'(-x);
		// floor for negative x: -(|x| + 4) / 5
		if (x[MB_W-1]) mag_for_div5 = neg_x[MAG_W-1:0] + MAG_W'(4);
		else           mag_for_div5 = x[MAG_W-1:0];
	endfunction

	function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [MB_W:0] v);
		if (v[MB_W])                        clamp_speed = '0;
		else if (v > (MB_W+1)'(255))        clamp_speed = '1;
		else                                clamp_speed = v[SPEED_W-1:0];
	endfunction

	// base + floor(x / 5) using the registered quotient magnitude
	function automatic logic [SPEED_W-1:0] mix_fifth(input logic [SPEED_W-1:0] base,
			input logic neg, input logic [QUO_W-1:0] q);
		logic signed [MB_W:0] d;
		d = (MB_W+1)'(q);
		if (neg) d = -d;
		mix_fifth = clamp_speed((MB_W+1)'(base) + d);
	endfunction

	// base + floor(x / 2); shift on its own so it stays arithmetic
	function automatic logic [SPEED_W-1:0] mix_half(input logic [SPEED_W-1:0] base,
			input logic signed [PID_W-1:0] x, input logic negate);
		logic signed [MB_W:0] xe;
		xe = (MB_W+1)'(x);
		if (negate) xe = -xe;
		xe = xe >>> 1;
		mix_half = clamp_speed((MB_W+1)'(base) + xe);
	endfunction

	// error on intake
	assign err_raw = $signed({1'b0, sensor_value}) - $signed(SENSOR_CENTER);
	assign err_new = cfg.reverse ? -err_raw : err_raw;

	assign sum_ext = $signed({sum_q[SUM_WIDTH-1], sum_q}) + (SUM_WIDTH+1)'(err_q);

	always_comb begin
		case (ctrl.a_sel)
			A_ERR:   mul_a = MA_W'(err_q);
			A_DERIV: mul_a = MA_W'(deriv_q);
			A_SUM:   mul_a = MA_W'(sum_q);
			A_RECIP: mul_a = MA_W'(RECIP_VAL);
			default: mul_a = '0;
		endcase
		case (ctrl.b_sel)
			B_GP:    mul_b = MB_W'(cfg.gain_p);
			B_GI:    mul_b = MB_W'(cfg.gain_i);
			B_GD:    mul_b = MB_W'(cfg.gain_d);
			B_NL:    mul_b = $signed({1'b0, nl});
			B_NR:    mul_b = $signed({1'b0, nr});
			default: mul_b = '0;
		endcase
	end

	// truncate toward zero, then saturate to int16
	always_comb begin
		acc_adj = acc_q + (acc_q[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
		acc_sh  = acc_adj >>> 8;
		if (acc_sh > ACC_W'(32767))       pid_sat = 16'sh7FFF;
		else if (acc_sh < -ACC_W'(32768)) pid_sat = -16'sh8000;
		else                              pid_sat = acc_sh[PID_W-1:0];
	end

	assign pid3 = MB_W'(pid_q) + (MB_W'(pid_q) <<< 1);
	assign xl3  = -pid3;
	assign xr3  = pid3;
	assign nl   = mag_for_div5(xl3);
	assign nr   = mag_for_div5(xr3);
	assign quo  = prod_q[RECIP_SHIFT +: QUO_W];

	assign left_nxt  = (cfg.turn_mode == MODE_RIGHT) ? mix_half(cfg.base_left, pid_q, 1'b1)
		: mix_fifth(cfg.base_left, xl3[MB_W-1], quo);
	assign right_nxt = (cfg.turn_mode == MODE_LEFT) ? mix_half(cfg.base_right, pid_q, 1'b0)
		: mix_fifth(cfg.base_right, xr3[MB_W-1], quo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q <= '0;
			sum_q   <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			if (load) prior_q <= err_new;
			if (ctrl.sum_wr) begin
				if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1])
					sum_q <= {sum_ext[SUM_WIDTH], {(SUM_WIDTH-1){~sum_ext[SUM_WIDTH]}}};
				else
					sum_q <= sum_ext[SUM_WIDTH-1:0];
			end
			if (ctrl.left_wr)  left_q  <= left_nxt;
			if (ctrl.right_wr) right_q <= right_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			err_q   <= err_new;
			deriv_q <= DERIV_W'(err_new) - DERIV_W'(prior_q);
		end
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		case (ctrl.acc_op)
			ACC_LOAD: acc_q <= ACC_W'(prod_q);
			ACC_ADD:  acc_q <= acc_q + ACC_W'(prod_q);
			default:  acc_q <= acc_q;
		endcase
		if (ctrl.pid_wr) pid_q <= pid_sat;
	end

	assign left_speed  = left_q;
	assign right_speed = right_q;

endmodule

/* rtl/line_follow_pid_wheel_mixer.sv */
// line_follow_pid_wheel_mixer: top level; config registers, stream handshakes, output register.
// Depends on lfpwm_pkg, lfpwm_seq, lfpwm_dp.
`timescale 1ns / 1ps

// Line-follow PID controller with differential wheel mixing.
// Input stream: one sensor reading per transaction on s_tdata[7:0].
// Output stream: one transaction per input, m_tdata = {right_speed, left_speed}.
// Config: cfg_we/cfg_index/cfg_data write one register per cycle; write only while idle
//   (no transaction in flight). Index 7 is ignored.
// Sequencing: a microcoded sequencer runs a 9-step program over one shared MA_W x 18
//   multiplier (24x18 at the default SUM_WIDTH): 3 multiply-accumulate steps, PID
//   saturate, two reciprocal-multiply divide-by-5 steps, two wheel writes and an emit step.
//   In hold mode the program skips from its first step straight to the emit step.
//   s_tready is high only while the sequencer is idle, so a new reading is not
//   accepted until the previous result has been emitted.
// Back-pressure: the result sits in an output register; the next input is still
//   accepted and processed, and the sequencer waits at its emit step only if the
//   output register is still full when the next result is ready.
// Reset (arst_n low): gains 1.0/0/0, bases 128, mode 0, forward; error history,
//   integral and held speeds clear to zero; both streams go idle.

module line_follow_pid_wheel_mixer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [7:0]                         s_tdata,   // [7:0] sensor_value
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [15:0]                        m_tdata,   // [7:0] left_speed, [15:8] right_speed
	input  logic                               cfg_we,
	input  logic [lfpwm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lfpwm_pkg::CFG_W-1:0]        cfg_data
);
	import lfpwm_pkg::*;

	cfg_t               cfg_q;
	ctrl_t              ctrl;
	logic               busy, accept, stall, emit_fire, m_tvalid_q;
	logic [SPEED_W-1:0] left_speed, right_speed;
	logic [15:0]        m_tdata_q;

	assign s_tready  = !busy;
	assign accept    = s_tvalid && s_tready;
	// output slot is full and not draining this cycle
	assign stall     = m_tvalid_q && !m_tready;
	assign emit_fire = ctrl.emit && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p     <= 16'sd256;
			cfg_q.gain_i     <= '0;
			cfg_q.gain_d     <= '0;
			cfg_q.base_left  <= 8'd128;
			cfg_q.base_right <= 8'd128;
			cfg_q.turn_mode  <= MODE_STRAIGHT;
			cfg_q.reverse    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GAIN_P:     cfg_q.gain_p     <= cfg_data;
				CFG_GAIN_I:     cfg_q.gain_i     <= cfg_data;
				CFG_GAIN_D:     cfg_q.gain_d     <= cfg_data;
				CFG_BASE_LEFT:  cfg_q.base_left  <= cfg_data[SPEED_W-1:0];
				CFG_BASE_RIGHT: cfg_q.base_right <= cfg_data[SPEED_W-1:0];
				CFG_TURN_MODE:  cfg_q.turn_mode  <= cfg_data[1:0];
				CFG_REVERSE:    cfg_q.reverse    <= cfg_data[0];
				default:        ;
			endcase
		end
	end

	lfpwm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.hold   (cfg_q.turn_mode == MODE_HOLD),
		.stall  (stall),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	lfpwm_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.sensor_value (s_tdata[SENSOR_W-1:0]),
		.cfg          (cfg_q),
		.ctrl         (ctrl),
		.left_speed   (left_speed),
		.right_speed  (right_speed)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) m_tdata_q <= {right_speed, left_speed};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("sequencer not busy after accept");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit_fire |-> (!m_tvalid_q || m_tready))
		else $error("result loaded over an undelivered result");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctrl.sum_wr, ctrl.pid_wr, ctrl.left_wr, ctrl.right_wr, ctrl.emit}))
		else $error("more than one write strobe in a step");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !ctrl.emit && !ctrl.sum_wr)
		else $error("control active while idle");
`endif

endmodule
